FILE: design/ibh_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ibh_pkg
// Shared sizes, codes, entry type and controller/datapath handoff structs
// for the indexed binary min-heap.
// ----------------------------------------------------------------------------
package ibh_pkg;

  localparam int CAPACITY  = 256;
  localparam int ID_COUNT  = 256;
  localparam int KEY_WIDTH = 32;

  localparam int ID_W    = $clog2(ID_COUNT);
  localparam int SLOT_W  = $clog2(CAPACITY + 1);
  localparam int ADDR_W  = $clog2(CAPACITY);
  localparam int CHILD_W = SLOT_W + 1;

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_POP    = 2'd1,
    MODE_REMOVE = 2'd2,
    MODE_CLEAR  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_FULL   = 2'd2,
    ST_ABSENT = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MAPRD,
    S_DECIDE,
    S_TK_RDK,
    S_TK_RDL,
    S_TK_EVAL,
    S_INS_START,
    S_UP_CHK,
    S_UP_CMP,
    S_DN_CHK,
    S_DN_RD2,
    S_DN_CMP,
    S_PLACE,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [ID_W-1:0]      id;
    logic [KEY_WIDTH-1:0] key;
  } entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    latch_in;
    logic    map_rd;
    logic    take_found;
    logic    take_root;
    logic    set_pending;
    logic    set_status;
    status_e status_val;
    logic    clear_all;
    logic    rd_k;
    logic    rd_last;
    logic    tk_eval;
    logic    ins_start;
    logic    up_rd;
    logic    up_move;
    logic    dn_rd_left;
    logic    dn_capture;
    logic    dn_rd_right;
    logic    dn_move;
    logic    place;
    logic    out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    mode_e mode;
    logic  present;
    logic  cnt_zero;
    logic  cnt_full;
    logic  k_is_last;
    logic  last_lt_gone;
    logic  gap_gt1;
    logic  up_less;
    logic  child_in;
    logic  right_in;
    logic  dn_less;
    logic  pending;
    logic  out_free;
  } sts_t;

endpackage
`default_nettype wire

FILE: design/ibh_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ibh_if
// Valid/ready channels for heap requests and heap responses.
// ----------------------------------------------------------------------------
interface ibh_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [7:0]  item_id;
  logic [31:0] priority_key;

  modport source (output valid, output mode, output item_id, output priority_key,
                  input ready);
  modport sink (input valid, input mode, input item_id, input priority_key,
                output ready);
endinterface

interface ibh_rsp_if;
  logic        valid;
  logic        ready;
  logic [7:0]  result_id;
  logic [31:0] result_key;
  logic [1:0]  status;
  logic [8:0]  entry_count;

  modport source (output valid, output result_id, output result_key, output status,
                  output entry_count, input ready);
  modport sink (input valid, input result_id, input result_key, input status,
                input entry_count, output ready);
endinterface
`default_nettype wire

FILE: design/ibh_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ibh_ctrl
// Operation sequencer: lookup, take-out, sift-up and sift-down walks.
// ----------------------------------------------------------------------------
module ibh_ctrl import ibh_pkg::*; (
  input  wire  clk_i,
  input  wire  rst_ni,
  input  wire  req_valid_i,
  output logic req_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    cmd_o.status_val = ST_OK;
    req_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.latch_in = 1'b1;
          state_d = S_MAPRD;
        end
      end
      S_MAPRD: begin
        cmd_o.map_rd = 1'b1;
        state_d = S_DECIDE;
      end
      S_DECIDE: begin
        unique case (sts_i.mode)
          MODE_INSERT: begin
            if (sts_i.present) begin
              cmd_o.take_found  = 1'b1;
              cmd_o.set_pending = 1'b1;
              state_d = S_TK_RDK;
            end else if (sts_i.cnt_full) begin
              cmd_o.set_status = 1'b1;
              cmd_o.status_val = ST_FULL;
              state_d = S_DONE;
            end else begin
              state_d = S_INS_START;
            end
          end
          MODE_POP: begin
            if (sts_i.cnt_zero) begin
              cmd_o.set_status = 1'b1;
              cmd_o.status_val = ST_EMPTY;
              state_d = S_DONE;
            end else begin
              cmd_o.take_root = 1'b1;
              state_d = S_TK_RDK;
            end
          end
          MODE_REMOVE: begin
            if (sts_i.present) begin
              cmd_o.take_found = 1'b1;
              state_d = S_TK_RDK;
            end else begin
              cmd_o.set_status = 1'b1;
              cmd_o.status_val = ST_ABSENT;
              state_d = S_DONE;
            end
          end
          MODE_CLEAR: begin
            cmd_o.clear_all = 1'b1;
            state_d = S_DONE;
          end
          default: state_d = S_DONE;
        endcase
      end
      S_TK_RDK: begin
        cmd_o.rd_k = 1'b1;
        state_d = S_TK_RDL;
      end
      S_TK_RDL: begin
        cmd_o.rd_last = 1'b1;
        state_d = S_TK_EVAL;
      end
      S_TK_EVAL: begin
        cmd_o.tk_eval = 1'b1;
        if (sts_i.k_is_last) begin
          state_d = sts_i.pending ? S_INS_START : S_DONE;
        end else if (sts_i.last_lt_gone) begin
          state_d = S_UP_CHK;
        end else begin
          state_d = S_DN_CHK;
        end
      end
      S_INS_START: begin
        cmd_o.ins_start = 1'b1;
        state_d = S_UP_CHK;
      end
      S_UP_CHK: begin
        if (sts_i.gap_gt1) begin
          cmd_o.up_rd = 1'b1;
          state_d = S_UP_CMP;
        end else begin
          state_d = S_PLACE;
        end
      end
      S_UP_CMP: begin
        if (sts_i.up_less) begin
          cmd_o.up_move = 1'b1;
          state_d = S_UP_CHK;
        end else begin
          state_d = S_PLACE;
        end
      end
      S_DN_CHK: begin
        if (sts_i.child_in) begin
          cmd_o.dn_rd_left = 1'b1;
          state_d = S_DN_RD2;
        end else begin
          state_d = S_PLACE;
        end
      end
      S_DN_RD2: begin
        cmd_o.dn_capture  = 1'b1;
        cmd_o.dn_rd_right = sts_i.right_in;
        state_d = S_DN_CMP;
      end
      S_DN_CMP: begin
        if (sts_i.dn_less) begin
          cmd_o.dn_move = 1'b1;
          state_d = S_DN_CHK;
        end else begin
          state_d = S_PLACE;
        end
      end
      S_PLACE: begin
        cmd_o.place = 1'b1;
        state_d = sts_i.pending ? S_INS_START : S_DONE;
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

FILE: design/ibh_dpath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ibh_dpath
// Heap slot memory, id-to-slot map, walk registers and response register.
// ----------------------------------------------------------------------------
module ibh_dpath import ibh_pkg::*; (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire [1:0]            req_mode_i,
  input  wire [ID_W-1:0]       req_id_i,
  input  wire [KEY_WIDTH-1:0]  req_key_i,
  input  cmd_t                 cmd_i,
  output sts_t                 sts_o,
  ibh_rsp_if.source            rsp_o
);

  // Operation registers.
  mode_e                mode_q;
  logic [ID_W-1:0]      id_q;
  logic [KEY_WIDTH-1:0] key_q;
  status_e              status_q;
  logic [ID_W-1:0]      res_id_q;
  logic [KEY_WIDTH-1:0] res_key_q;
  logic [SLOT_W-1:0]    cnt_q;
  logic [SLOT_W-1:0]    k_q;
  logic [SLOT_W-1:0]    gap_q;
  entry_t               cur_q;
  entry_t               gone_q;
  entry_t               a_q;
  logic                 pending_q;

  // Memories.
  entry_t               heap_mem [CAPACITY];
  entry_t               rdata_q;
  logic [SLOT_W-1:0]    map_mem [ID_COUNT];
  logic [SLOT_W-1:0]    map_slot_q;
  logic [ID_COUNT-1:0]  map_vld_q;
  logic                 map_hit_q;

  // Response register.
  logic                 out_valid_q;
  logic [ID_W-1:0]      out_id_q;
  logic [KEY_WIDTH-1:0] out_key_q;
  logic [1:0]           out_status_q;
  logic [SLOT_W-1:0]    out_cnt_q;

  logic [CHILD_W-1:0]   child;
  logic [CHILD_W-1:0]   cnt_ext;
  logic                 pick_right;
  entry_t               sel;
  logic [SLOT_W-1:0]    sel_slot;
  logic                 heap_rd;
  logic [ADDR_W-1:0]    heap_raddr;
  logic                 heap_we;
  logic [ADDR_W-1:0]    heap_waddr;
  entry_t               heap_wdata;
  logic                 map_we;
  logic [ID_W-1:0]      map_waddr;

  // Walk geometry and comparisons.
  assign child      = {gap_q, 1'b0};
  assign cnt_ext    = {1'b0, cnt_q};
  assign pick_right = sts_o.right_in && (rdata_q.key < a_q.key);
  assign sel        = pick_right ? rdata_q : a_q;
  assign sel_slot   = pick_right ? SLOT_W'(child + CHILD_W'(1)) : SLOT_W'(child);

  always_comb begin
    sts_o.mode         = mode_q;
    sts_o.present      = map_hit_q;
    sts_o.cnt_zero     = (cnt_q == '0);
    sts_o.cnt_full     = (cnt_q == SLOT_W'(CAPACITY));
    sts_o.k_is_last    = (k_q == cnt_q);
    sts_o.last_lt_gone = (rdata_q.key < gone_q.key);
    sts_o.gap_gt1      = (gap_q > SLOT_W'(1));
    sts_o.up_less      = (cur_q.key < rdata_q.key);
    sts_o.child_in     = (child <= cnt_ext);
    sts_o.right_in     = (child < cnt_ext);
    sts_o.dn_less      = (sel.key < cur_q.key);
    sts_o.pending      = pending_q;
    sts_o.out_free     = !out_valid_q || rsp_o.ready;
  end

  // Heap memory read address select.
  always_comb begin
    heap_rd    = 1'b1;
    heap_raddr = '0;
    priority if (cmd_i.rd_k) begin
      heap_raddr = ADDR_W'(k_q - SLOT_W'(1));
    end else if (cmd_i.rd_last) begin
      heap_raddr = ADDR_W'(cnt_q - SLOT_W'(1));
    end else if (cmd_i.up_rd) begin
      heap_raddr = ADDR_W'((gap_q >> 1) - SLOT_W'(1));
    end else if (cmd_i.dn_rd_left) begin
      heap_raddr = ADDR_W'(child - CHILD_W'(1));
    end else if (cmd_i.dn_rd_right) begin
      heap_raddr = ADDR_W'(child);
    end else begin
      heap_rd = 1'b0;
    end
  end

  // Heap memory and map write select: the entry moved into the gap.
  always_comb begin
    heap_we    = cmd_i.up_move || cmd_i.dn_move || cmd_i.place;
    heap_waddr = ADDR_W'(gap_q - SLOT_W'(1));
    priority if (cmd_i.up_move) begin
      heap_wdata = rdata_q;
    end else if (cmd_i.dn_move) begin
      heap_wdata = sel;
    end else begin
      heap_wdata = cur_q;
    end
    map_we    = heap_we;
    map_waddr = heap_wdata.id;
  end

  // Heap memory.
  always_ff @(posedge clk_i) begin
    if (heap_we) begin
      heap_mem[heap_waddr] <= heap_wdata;
    end
    if (heap_rd) begin
      rdata_q <= heap_mem[heap_raddr];
    end
  end

  // Id-to-slot map storage.
  always_ff @(posedge clk_i) begin
    if (map_we) begin
      map_mem[map_waddr] <= gap_q;
    end
    if (cmd_i.map_rd) begin
      map_slot_q <= map_mem[id_q];
    end
  end

  // Map valid bits; an id without a valid bit is absent.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_vld_q <= '0;
      map_hit_q <= 1'b0;
    end else begin
      if (cmd_i.map_rd) begin
        map_hit_q <= map_vld_q[id_q];
      end
      if (cmd_i.clear_all) begin
        map_vld_q <= '0;
      end else if (map_we) begin
        map_vld_q[map_waddr] <= 1'b1;
      end else if (cmd_i.tk_eval) begin
        map_vld_q[gone_q.id] <= 1'b0;
      end
    end
  end

  // Control registers: entry count and pending insert.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      pending_q <= 1'b0;
    end else begin
      if (cmd_i.clear_all) begin
        cnt_q <= '0;
      end else if (cmd_i.tk_eval) begin
        cnt_q <= cnt_q - SLOT_W'(1);
      end else if (cmd_i.ins_start) begin
        cnt_q <= cnt_q + SLOT_W'(1);
      end
      if (cmd_i.set_pending) begin
        pending_q <= 1'b1;
      end else if (cmd_i.ins_start) begin
        pending_q <= 1'b0;
      end
    end
  end

  // Operation payload and walk registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      mode_q    <= mode_e'(req_mode_i);
      id_q      <= req_id_i;
      key_q     <= req_key_i;
      status_q  <= ST_OK;
      res_id_q  <= '0;
      res_key_q <= '0;
    end
    if (cmd_i.set_status) begin
      status_q <= cmd_i.status_val;
    end
    if (cmd_i.take_found) begin
      k_q <= map_slot_q;
    end else if (cmd_i.take_root) begin
      k_q <= SLOT_W'(1);
    end
    if (cmd_i.rd_last) begin
      gone_q <= rdata_q;
    end
    if (cmd_i.tk_eval) begin
      gap_q <= k_q;
      cur_q <= rdata_q;
      if (mode_q == MODE_POP) begin
        res_id_q  <= gone_q.id;
        res_key_q <= gone_q.key;
      end
    end else if (cmd_i.ins_start) begin
      gap_q  <= cnt_q + SLOT_W'(1);
      cur_q.id  <= id_q;
      cur_q.key <= key_q;
    end else if (cmd_i.up_move) begin
      gap_q <= gap_q >> 1;
    end else if (cmd_i.dn_move) begin
      gap_q <= sel_slot;
    end
    if (cmd_i.dn_capture) begin
      a_q <= rdata_q;
    end
  end

  // Response register: holds a result until it is transferred.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_id_q     <= res_id_q;
      out_key_q    <= res_key_q;
      out_status_q <= status_q;
      out_cnt_q    <= cnt_q;
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.result_id   = out_id_q;
  assign rsp_o.result_key  = out_key_q;
  assign rsp_o.status      = out_status_q;
  assign rsp_o.entry_count = out_cnt_q;

endmodule
`default_nettype wire

FILE: design/indexed_binary_min_heap.sv
`timescale 1ns / 1ps
`default_nettype none
// A take-out moves the last entry into the freed slot and walks it up or down, unless
// the last slot itself goes; an insert that replaces an id runs both a take-out and
// a fresh insert.
// Throughput: one operation at a time; a held response stalls the next load.
// Reset empties the heap and the id map at once.
// ----------------------------------------------------------------------------
// indexed_binary_min_heap
// Indexed binary min-heap with insert, pop-minimum, remove by id and clear.
// ----------------------------------------------------------------------------
module indexed_binary_min_heap import ibh_pkg::*; (
  input  wire       clk_i,
  input  wire       rst_ni,
  ibh_req_if.sink   req_i,
  ibh_rsp_if.source rsp_o
);

  cmd_t cmd;
  sts_t sts;
  logic req_ready;

  assign req_i.ready = req_ready;

  ibh_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  ibh_dpath u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_mode_i (req_i.mode),
    .req_id_i   (req_i.item_id),
    .req_key_i  (req_i.priority_key),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .rsp_o      (rsp_o)
  );

  // The count never exceeds the capacity.
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> (rsp_o.entry_count <= 9'(CAPACITY)))
    else $error("entry count above capacity");

  // An empty pop reports an empty heap.
  a_empty_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && (rsp_o.status == ST_EMPTY)) |-> (rsp_o.entry_count == '0))
    else $error("empty status with entries held");

  // A full insert reports a full heap.
  a_full_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && (rsp_o.status == ST_FULL)) |-> (rsp_o.entry_count == 9'(CAPACITY)))
    else $error("full status without a full heap");

  // After a request transfer the block is busy with that operation.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> !req_i.ready)
    else $error("new request taken while an operation runs");

endmodule
`default_nettype wire
